// File: src/tpae_pkg.sv
// ----------------------------------------------------------------------------
// Triangle plane, area and edge package
// Shared widths, derived from the coordinate width.
// ----------------------------------------------------------------------------
package tpae_pkg;

  localparam int COORD_BITS_DEF = 18;

  function automatic int nrm_w(input int cb);
    return 2 * cb + 2;
  endfunction

  function automatic int ofs_w(input int cb);
    return 3 * cb + 3;
  endfunction

  function automatic int area_w(input int cb);
    return 2 * cb + 3;
  endfunction

  function automatic int flat_w(input int cb);
    return 2 * cb + 1;
  endfunction

  function automatic int edge_w(input int cb);
    return cb + 1;
  endfunction

  function automatic int len2_w(input int cb);
    return 4 * cb + 6;
  endfunction

  function automatic int esq_w(input int cb);
    return 2 * cb + 3;
  endfunction

endpackage

// File: src/tpae_if.sv
// ----------------------------------------------------------------------------
// Triangle plane, area and edge channel interfaces
// Valid/ready channels for vertex beats and result beats.
// ----------------------------------------------------------------------------
interface tpae_in_if #(parameter int COORD_BITS = 18) (input logic clk);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tpae_out_if #(parameter int COORD_BITS = 18) (input logic clk);
  logic                           valid;
  logic                           ready;
  logic signed [2*COORD_BITS+1:0] normal_x, normal_y, normal_z;
  logic signed [3*COORD_BITS+2:0] plane_offset;
  logic        [2*COORD_BITS+2:0] area_doubled;
  logic        [2*COORD_BITS:0]   flat_area_doubled;
  logic        [COORD_BITS:0]     longest_edge;
  modport source (output valid, normal_x, normal_y, normal_z, plane_offset,
                  area_doubled, flat_area_doubled, longest_edge, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, plane_offset,
                  area_doubled, flat_area_doubled, longest_edge, output ready);
endinterface

// File: src/tpae_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: tries one result bit and passes the
// partial remainder, root and side payload to the next cell.
// ----------------------------------------------------------------------------
module tpae_sqrt_cell #(
  parameter int RAD_W = 8,
  parameter int ROOT_W = 4,
  parameter int STEP = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [RAD_W-1:0]  rad_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [SIDE_W-1:0] side_out
);
  localparam int BIT = ROOT_W - 1 - STEP;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [RAD_W+1:0]  trial;
  logic [RAD_W+1:0]  rad_ext;

  // Remainder tracks x - root^2; trying bit b costs (2*root + 2^b) << b.
  always_comb begin
    trial   = ({2'b0, RAD_W'(root_in)} << (BIT + 1)) + ((RAD_W+2)'(1) << (2 * BIT));
    rad_ext = {2'b0, rad_in};
    if (trial <= rad_ext) begin
      rad_nxt  = RAD_W'(rad_ext - trial);
      root_nxt = root_in | (ROOT_W'(1) << BIT);
    end else begin
      rad_nxt  = rad_in;
      root_nxt = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      side_r <= side_in;
    end
  end

  assign rad_out  = rad_r;
  assign root_out = root_r;
  assign side_out = side_r;
endmodule

// File: src/tpae_front.sv
// ----------------------------------------------------------------------------
// Geometry front end
// Six registered stages: differences, normal products and edge squares, the
// normal and edge maximum, split square products and dot products, the
// component squares and offset sum, then the squared length sum.
// ----------------------------------------------------------------------------
module tpae_front #(
  parameter int COORD_BITS = 18
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
  output logic signed [2*COORD_BITS+1:0] nx, ny, nz,
  output logic signed [3*COORD_BITS+2:0] ofs,
  output logic [4*COORD_BITS+5:0]        len2,
  output logic [2*COORD_BITS+2:0]        emax
);
  import tpae_pkg::*;
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * COORD_BITS + 2;
  localparam int O = ofs_w(COORD_BITS);
  localparam int L = len2_w(COORD_BITS);
  localparam int E = esq_w(COORD_BITS);
  localparam int LO = COORD_BITS + 1;
  localparam int H = P - LO;

  logic signed [D-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r, wx_r, wy_r;
  logic signed [COORD_BITS-1:0] cx1_r, cy1_r, cz1_r, cx2_r, cy2_r, cz2_r;
  logic signed [COORD_BITS-1:0] cx3_r, cy3_r, cz3_r;
  logic signed [P-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [E-1:0] e1_r, e2_r, e3_r, emx_r, emx2_r, emx3_r;
  logic signed [P-1:0] nx2_r, ny2_r, nz2_r, nx3_r, ny3_r, nz3_r, nx4_r, ny4_r, nz4_r;
  logic [2*H-1:0] hhx_r, hhy_r, hhz_r;
  logic signed [P:0] hlx_r, hly_r, hlz_r;
  logic [2*LO-1:0] llx_r, lly_r, llz_r;
  logic [L-1:0] sx_r, sy_r, sz_r;
  logic signed [O-1:0] dx_r, dy_r, dz_r, ofs_r;

  function automatic logic [E-1:0] esq(input logic signed [D-1:0] a,
                                       input logic signed [D-1:0] b);
    return E'(a * a) + E'(b * b);
  endfunction

  // A normal component is split as n = h * 2^LO + l with l unsigned.
  function automatic logic [2*H-1:0] sq_hh(input logic signed [P-1:0] n);
    return (2*H)'($signed(n[P-1:LO]) * $signed(n[P-1:LO]));
  endfunction

  function automatic logic signed [P:0] sq_hl(input logic signed [P-1:0] n);
    return (P+1)'($signed(n[P-1:LO]) * $signed({1'b0, n[LO-1:0]}));
  endfunction

  function automatic logic [2*LO-1:0] sq_ll(input logic signed [P-1:0] n);
    return (2*LO)'(n[LO-1:0] * n[LO-1:0]);
  endfunction

  function automatic logic [L-1:0] sq_join(input logic [2*H-1:0] hh,
                                           input logic signed [P:0] hl,
                                           input logic [2*LO-1:0] ll);
    return (L'(hh) << (2 * LO)) + (L'(hl) << (LO + 1)) + L'(ll);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= D'(ax) - D'(bx);  uy_r <= D'(ay) - D'(by);  uz_r <= D'(az) - D'(bz);
      vx_r <= D'(ax) - D'(cx);  vy_r <= D'(ay) - D'(cy);  vz_r <= D'(az) - D'(cz);
      wx_r <= D'(bx) - D'(cx);  wy_r <= D'(by) - D'(cy);
      cx1_r <= cx;  cy1_r <= cy;  cz1_r <= cz;
      p0_r <= P'(uy_r * vz_r);  p1_r <= P'(uz_r * vy_r);
      p2_r <= P'(uz_r * vx_r);  p3_r <= P'(ux_r * vz_r);
      p4_r <= P'(ux_r * vy_r);  p5_r <= P'(uy_r * vx_r);
      e1_r <= esq(ux_r, uy_r);  e2_r <= esq(vx_r, vy_r);  e3_r <= esq(wx_r, wy_r);
      cx2_r <= cx1_r;  cy2_r <= cy1_r;  cz2_r <= cz1_r;
      nx2_r <= p0_r - p1_r;  ny2_r <= p2_r - p3_r;  nz2_r <= p4_r - p5_r;
      emx_r <= (e1_r >= e2_r) ? ((e1_r >= e3_r) ? e1_r : e3_r)
                              : ((e2_r >= e3_r) ? e2_r : e3_r);
      cx3_r <= cx2_r;  cy3_r <= cy2_r;  cz3_r <= cz2_r;
      nx3_r <= nx2_r;  ny3_r <= ny2_r;  nz3_r <= nz2_r;
      emx2_r <= emx_r;
      hhx_r <= sq_hh(nx2_r);  hhy_r <= sq_hh(ny2_r);  hhz_r <= sq_hh(nz2_r);
      hlx_r <= sq_hl(nx2_r);  hly_r <= sq_hl(ny2_r);  hlz_r <= sq_hl(nz2_r);
      llx_r <= sq_ll(nx2_r);  lly_r <= sq_ll(ny2_r);  llz_r <= sq_ll(nz2_r);
      dx_r  <= O'(nx2_r * cx3_r);  dy_r <= O'(ny2_r * cy3_r);
      dz_r  <= O'(nz2_r * cz3_r);
      nx4_r <= nx3_r;  ny4_r <= ny3_r;  nz4_r <= nz3_r;
      emx3_r <= emx2_r;
      sx_r  <= sq_join(hhx_r, hlx_r, llx_r);
      sy_r  <= sq_join(hhy_r, hly_r, lly_r);
      sz_r  <= sq_join(hhz_r, hlz_r, llz_r);
      ofs_r <= O'(0) - dx_r - dy_r - dz_r;
      nx <= nx4_r;  ny <= ny4_r;  nz <= nz4_r;
      emax <= emx3_r;
      ofs  <= ofs_r;
      len2 <= sx_r + sy_r + sz_r;
    end
  end
endmodule

// File: src/triangle_plane_area_edge_core.sv
// ----------------------------------------------------------------------------
// Triangle plane, area and edge core
// Normal, plane offset, doubled areas and longest XY edge of one triangle.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  in_      in   vertices A, B, C
//  out_     out  normal, offset, areas, longest edge
//
//  One triangle a cycle unless the output stalls; path: 6 front stages, the
//  area root chain (2*COORD_BITS+3 cells, one per root bit), output register.
//  rst_n clears only the valid bits of the pipeline.
//  The whole pipeline advances when the output register is free or taken,
//  so a stalled result holds every stage.
module triangle_plane_area_edge_core #(
  parameter int COORD_BITS = tpae_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tpae_in_if.sink    in_ch,
  tpae_out_if.source out_ch
);
  import tpae_pkg::*;
  localparam int FRONT = 6;
  localparam int NW = nrm_w(COORD_BITS);
  localparam int OW = ofs_w(COORD_BITS);
  localparam int AW = area_w(COORD_BITS);
  localparam int FW = flat_w(COORD_BITS);
  localparam int EW = edge_w(COORD_BITS);
  localparam int LW = len2_w(COORD_BITS);
  localparam int QW = esq_w(COORD_BITS);
  localparam int ENR = 2 * EW;
  localparam int SIDE_W = 3 * NW + OW;
  localparam int DEPTH = FRONT + AW;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic out_vld_r;

  logic signed [NW-1:0] nx, ny, nz;
  logic signed [OW-1:0] ofs;
  logic [LW-1:0] len2;
  logic [QW-1:0] emax;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[DEPTH-2:0], in_ch.valid};
      out_vld_r <= vld_r[DEPTH-1];
    end
  end

  tpae_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .en(en),
    .ax(in_ch.a_x), .ay(in_ch.a_y), .az(in_ch.a_z),
    .bx(in_ch.b_x), .by(in_ch.b_y), .bz(in_ch.b_z),
    .cx(in_ch.c_x), .cy(in_ch.c_y), .cz(in_ch.c_z),
    .nx(nx), .ny(ny), .nz(nz), .ofs(ofs), .len2(len2), .emax(emax)
  );

  // Area root chain; the edge root runs in its own shorter chain and is
  // then delayed to line up with the area root.
  logic [LW-1:0]     rad  [AW+1];
  logic [AW-1:0]     root [AW+1];
  logic [SIDE_W-1:0] side [AW+1];
  logic [ENR-1:0]    erad [EW+1];
  logic [EW-1:0]     eroot[EW+1];

  assign rad[0]  = len2;
  assign root[0] = '0;
  assign side[0] = {nx, ny, nz, ofs};

  for (genvar i = 0; i < AW; i++) begin : g_area
    tpae_sqrt_cell #(.RAD_W(LW), .ROOT_W(AW), .STEP(i), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .en(en), .rad_in(rad[i]), .root_in(root[i]), .side_in(side[i]),
      .rad_out(rad[i+1]), .root_out(root[i+1]), .side_out(side[i+1])
    );
  end

  assign erad[0]  = ENR'(emax);
  assign eroot[0] = '0;
  for (genvar j = 0; j < EW; j++) begin : g_edge
    logic edge_tag;
    tpae_sqrt_cell #(.RAD_W(ENR), .ROOT_W(EW), .STEP(j), .SIDE_W(1)) u_cell (
      .clk(clk), .en(en), .rad_in(erad[j]), .root_in(eroot[j]), .side_in(1'b0),
      .rad_out(erad[j+1]), .root_out(eroot[j+1]), .side_out(edge_tag)
    );
  end

  // The edge root chain is shorter; delay its result to line up with the area root.
  logic [EW-1:0] edly_r [AW-EW+1];
  assign edly_r[0] = eroot[EW];
  for (genvar k = 0; k < AW - EW; k++) begin : g_edly
    always_ff @(posedge clk) begin
      if (en) edly_r[k+1] <= edly_r[k];
    end
  end

  logic signed [NW-1:0] fnx, fny, fnz;
  logic signed [OW-1:0] fofs;
  assign fnx  = side[AW][SIDE_W-1 -: NW];
  assign fny  = side[AW][SIDE_W-1-NW -: NW];
  assign fnz  = side[AW][SIDE_W-1-2*NW -: NW];
  assign fofs = side[AW][SIDE_W-1-3*NW -: OW];

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.normal_x          <= fnx;
      out_ch.normal_y          <= fny;
      out_ch.normal_z          <= fnz;
      out_ch.plane_offset      <= fofs;
      out_ch.area_doubled      <= root[AW];
      out_ch.flat_area_doubled <= fnz[NW-1] ? FW'(-fnz) : FW'(fnz);
      out_ch.longest_edge      <= edly_r[AW-EW];
    end
  end

  assign out_ch.valid = out_vld_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_ch.area_doubled))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_vld_r || out_ch.ready))
    else $error("ready does not follow output register");
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> AW'(out_ch.flat_area_doubled) <= out_ch.area_doubled)
    else $error("flat area exceeds area");
endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Triangle plane, area and edge core testbench
// Drives vertex beats from a directed table and then at random, predicts the
// normal, plane offset, doubled areas and longest XY edge of every triangle,
// and compares each result beat with the expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = tpae_pkg::COORD_BITS_DEF;
  localparam int NW = tpae_pkg::nrm_w(CB);
  localparam int OW = tpae_pkg::ofs_w(CB);
  localparam int AW = tpae_pkg::area_w(CB);
  localparam int FW = tpae_pkg::flat_w(CB);
  localparam int EW = tpae_pkg::edge_w(CB);
  localparam int LATENCY = 6 + AW + 1;
  localparam int N_RANDOM = 1700;
  localparam int N_DIRECTED = 12;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic signed [NW-1:0] nx, ny, nz;
    logic signed [OW-1:0] ofs;
    logic [AW-1:0] area;
    logic [FW-1:0] flat;
    logic [EW-1:0] edge_len;
  } geom_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycles = 0;
  int mismatches = 0;
  bit in_idle_off = 1'b0;
  bit out_idle_off = 1'b0;
  bit stim_done = 1'b0;
  geom_t expected_geom[$];

  tpae_in_if #(.COORD_BITS(CB)) in_ch (clk);
  tpae_out_if #(.COORD_BITS(CB)) out_ch (clk);

  triangle_plane_area_edge_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [127:0] isqrt(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic geom_t triangle_geometry(tri_t t);
    longint ux, uy, uz, vx, vy, vz, wx, wy, nx, ny, nz, ofs;
    logic [127:0] len2, e1, e2, e3, emax;
    geom_t g;
    ux = longint'(t.ax) - longint'(t.bx);
    uy = longint'(t.ay) - longint'(t.by);
    uz = longint'(t.az) - longint'(t.bz);
    vx = longint'(t.ax) - longint'(t.cx);
    vy = longint'(t.ay) - longint'(t.cy);
    vz = longint'(t.az) - longint'(t.cz);
    wx = longint'(t.bx) - longint'(t.cx);
    wy = longint'(t.by) - longint'(t.cy);
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    ofs = -(nx * longint'(t.cx) + ny * longint'(t.cy) + nz * longint'(t.cz));
    len2 = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
    e1 = 128'(ux * ux + uy * uy);
    e2 = 128'(vx * vx + vy * vy);
    e3 = 128'(wx * wx + wy * wy);
    emax = e1;
    if (e2 > emax) emax = e2;
    if (e3 > emax) emax = e3;
    g.nx = NW'(nx);
    g.ny = NW'(ny);
    g.nz = NW'(nz);
    g.ofs = OW'(ofs);
    g.area = AW'(isqrt(len2));
    g.flat = FW'(nz < 0 ? -nz : nz);
    g.edge_len = EW'(isqrt(emax));
    return g;
  endfunction

  function automatic coord_t rand_coord(int span);
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return coord_t'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic tri_t rand_triangle();
    tri_t t;
    int span;
    span = $urandom_range(0, 1) ? 1 << (CB - 1) : $urandom_range(1, 300);
    t.ax = rand_coord(span); t.ay = rand_coord(span); t.az = rand_coord(span);
    t.bx = rand_coord(span); t.by = rand_coord(span); t.bz = rand_coord(span);
    t.cx = rand_coord(span); t.cy = rand_coord(span); t.cz = rand_coord(span);
    if ($urandom_range(0, 9) == 0) begin
      // Collinear: C = A + k(B - A).
      t.cx = coord_t'(t.ax + 2 * (t.bx - t.ax));
      t.cy = coord_t'(t.ay + 2 * (t.by - t.ay));
      t.cz = coord_t'(t.az + 2 * (t.bz - t.az));
      t = (span < 1000) ? t : '0;
    end
    return t;
  endfunction

  tri_t directed_tri[N_DIRECTED];
  geom_t directed_geom[N_DIRECTED];
  bit directed_known[N_DIRECTED];

  initial begin
    directed_tri[0] = '0;
    directed_known[0] = 1'b1;
    directed_geom[0] = '0;
    directed_tri[1] = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
    directed_known[1] = 1'b1;
    directed_geom[1] = '0;
    directed_tri[2] = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
    directed_known[2] = 1'b1;
    directed_geom[2] = '0;
    directed_tri[3] = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    directed_known[3] = 1'b1;
    directed_geom[3] = '{0, 0, 1, 0, 1, 1, 1};
    directed_tri[4] = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX};
    directed_tri[5] = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN};
    directed_tri[6] = '{CMIN, CMIN, 0, CMAX, CMAX, 0, CMIN, CMAX, 0};
    directed_tri[7] = '{0, 0, CMIN, 0, 0, CMAX, 5, 5, 0};
    directed_tri[8] = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    directed_tri[9] = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN};
    directed_tri[10] = '{-1, -1, -1, CMAX, 0, CMIN, 0, CMIN, CMAX};
    directed_tri[11] = '{CMAX, 0, CMIN, CMIN, CMAX, 0, 0, CMIN, CMAX};
    for (int i = 4; i < N_DIRECTED; i++) directed_known[i] = 1'b0;
  end

  task automatic send_triangle(tri_t t);
    int gap;
    if (!in_idle_off && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} <= t;
    do @(posedge clk); while (!in_ch.ready);
    expected_geom.push_back(triangle_geometry(t));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    geom_t got;
    geom_t want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.plane_offset,
              out_ch.area_doubled, out_ch.flat_area_doubled, out_ch.longest_edge};
      if (expected_geom.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      end else begin
        want = expected_geom.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!out_idle_off && out_ch.ready && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    out_ch.ready = 1'b1;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_known[i] && triangle_geometry(directed_tri[i]) !== directed_geom[i])
        $display("Directed row %0d: table disagrees with prediction", i);
      send_triangle(directed_tri[i]);
      if (directed_known[i]) expected_geom[$] = directed_geom[i];
    end
    in_ch.valid <= 1'b0;
    while (expected_geom.size() != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 300) begin
        in_idle_off = 1'b1;
        out_idle_off = 1'b1;
      end
      send_triangle(rand_triangle());
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (expected_geom.size() != 0 && cycles < CYCLE_LIMIT) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && expected_geom.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
